// ===== sv/fwva_pkg.sv =====
// Package for the flagged weighted visibility averager.
// Holds shared constants, op codes and the front-to-back command struct.
// No dependencies.
`default_nettype none
package fwva_pkg;
  localparam int NUM_ANT_DEF  = 16;
  localparam int NUM_CHAN_DEF = 64;
  localparam int NUM_CORR_DEF = 4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] MODE_BASE = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_ANT  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SWAP_A = 2'd1;
  localparam logic [1:0] REG_SWAP_B = 2'd2;

  // Kinds of work that the back part carries out.
  localparam logic [1:0] K_CLEAR = 2'd0;
  localparam logic [1:0] K_ACC   = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_ZERO  = 2'd3;

  // Bins, channels and correlations are carried at maximum widths; the back
  // part folds them into an address with its own parameters.
  typedef struct packed {
    logic [1:0]         kind;
    logic               dual;      // per-antenna: second cell update present
    logic [11:0]        bin_i;
    logic [11:0]        bin_j;
    logic [11:0]        chan;
    logic [1:0]         corr;
    logic [1:0]         corr_j;    // swapped correlation for second antenna
    logic               flagged;
    logic [15:0]        weight;
    logic signed [15:0] vr;
    logic signed [15:0] vi;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/fwva_front.sv =====
// Front part: register file, decode and bin selection of input words.
// Depends on fwva_pkg.
`default_nettype none
module fwva_front #(
  parameter int NUM_ANT  = fwva_pkg::NUM_ANT_DEF,
  parameter int NUM_CHAN = fwva_pkg::NUM_CHAN_DEF,
  parameter int NUM_CORR = fwva_pkg::NUM_CORR_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_idx,
  input  wire logic [1:0]   cfg_val,
  output logic [5:0]        cfg_regs,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   op,
  input  wire logic [3:0]   ant1,
  input  wire logic [3:0]   ant2,
  input  wire logic [5:0]   chan,
  input  wire logic [1:0]   corr,
  input  wire logic         flg,
  input  wire logic [15:0]  wgt,
  input  wire logic [15:0]  vr,
  input  wire logic [15:0]  vi,
  input  wire logic [7:0]   rbin,
  output logic              q_push,
  output fwva_pkg::cmd_t    q_cmd,
  input  wire logic         q_full
);
  localparam int NUM_BINS = NUM_ANT * (NUM_ANT + 1) / 2;
  logic [1:0] mode_r, swa_r, swb_r;
  logic ok_cc, ok_ant;
  logic [11:0] tri_bin, a1, a2;
  logic [1:0] sc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; swa_r <= '0; swb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        fwva_pkg::REG_MODE:   mode_r <= cfg_val;
        fwva_pkg::REG_SWAP_A: swa_r  <= cfg_val;
        fwva_pkg::REG_SWAP_B: swb_r  <= cfg_val;
        default: ;
      endcase
    end
  end
  assign cfg_regs = {swb_r, swa_r, mode_r};

  assign a1 = {8'd0, ant1};
  assign a2 = {8'd0, ant2};
  assign ok_cc  = (32'(chan) < NUM_CHAN) && (32'(corr) < NUM_CORR);
  assign ok_ant = (32'(ant1) < NUM_ANT) && (32'(ant2) < NUM_ANT);
  // Triangular baseline index; the product is narrow (antenna below 16).
  assign tri_bin = 12'(NUM_ANT) * a1 - 12'((a1 * (a1 + 12'd1)) >> 1) + a2;

  always_comb begin
    sc = corr;
    if (swa_r != swb_r && 32'(swa_r) < NUM_CORR && 32'(swb_r) < NUM_CORR) begin
      if (corr == swa_r) sc = swb_r;
      else if (corr == swb_r) sc = swa_r;
    end
  end

  assign in_ready = !q_full;

  always_comb begin
    q_cmd = '0;
    q_push = 1'b0;
    q_cmd.chan = {6'd0, chan};
    q_cmd.corr = corr;
    q_cmd.corr_j = sc;
    q_cmd.flagged = flg;
    q_cmd.weight = wgt;
    q_cmd.vr = vr;
    q_cmd.vi = vi;
    if (in_valid && in_ready) begin
      case (op)
        fwva_pkg::OP_CLEAR: begin
          q_push = 1'b1;
          q_cmd.kind = fwva_pkg::K_CLEAR;
        end
        fwva_pkg::OP_ACC: begin
          q_cmd.kind = fwva_pkg::K_ACC;
          if (ok_cc) begin
            case (mode_r)
              fwva_pkg::MODE_ONE: begin
                q_push = 1'b1;
                q_cmd.bin_i = '0;
              end
              fwva_pkg::MODE_ANT: begin
                q_push = ok_ant;
                q_cmd.dual = 1'b1;
                q_cmd.bin_i = a1;
                q_cmd.bin_j = a2;
              end
              default: begin
                q_push = ok_ant && (ant2 >= ant1);
                q_cmd.bin_i = tri_bin;
              end
            endcase
          end
        end
        fwva_pkg::OP_READ: begin
          q_push = 1'b1;
          q_cmd.bin_i = {4'd0, rbin};
          q_cmd.kind = (ok_cc && 32'(rbin) < NUM_BINS) ? fwva_pkg::K_READ
                                                         : fwva_pkg::K_ZERO;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/fwva_queue.sv =====
// Two-entry queue between the front and the back parts.
// Depends on fwva_pkg.
`default_nettype none
module fwva_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire fwva_pkg::cmd_t din,
  output logic             full,
  output logic             valid,
  output fwva_pkg::cmd_t   dout,
  input  wire logic        pop
);
  fwva_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end
  assign full = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign dout = mem_r[rp_r];
endmodule
`default_nettype wire

// ===== sv/fwva_divider.sv =====
// Restoring divider: 40-bit signed sum by 32-bit unsigned weight, one
// quotient bit a cycle, truncated toward zero and saturated to 16 bits.
// Depends on nothing.
`default_nettype none
module fwva_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [39:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [15:0]      res
);
  logic [5:0]  cnt_r;
  logic        busy_r, neg_r, done_r;
  logic [39:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] trial;
  logic [39:0] mag;

  assign mag = num[39] ? (~num + 40'd1) : num;
  assign trial = {rem_r[31:0], q_r[39]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd40;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r <= mag; rem_r <= '0; den_r <= den; neg_r <= num[39];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r <= {q_r[38:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[39]};
        q_r <= {q_r[38:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg_r) res = (q_r > 40'd32767) ? 16'h7FFF : q_r[15:0];
    else res = (q_r > 40'd32768) ? 16'h8000 : 16'(~q_r + 40'd1);
  end
  assign done = done_r;
endmodule
`default_nettype wire

// ===== sv/fwva_back.sv =====
// Back part: cell store with epoch-marked clearing, flag rule, sums and reads.
// Depends on fwva_pkg and fwva_divider.
`default_nettype none
module fwva_back #(
  parameter int NUM_ANT  = fwva_pkg::NUM_ANT_DEF,
  parameter int NUM_CHAN = fwva_pkg::NUM_CHAN_DEF,
  parameter int NUM_CORR = fwva_pkg::NUM_CORR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire fwva_pkg::cmd_t q_cmd,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,
  output logic             out_tuser
);
  localparam int NUM_BINS = NUM_ANT * (NUM_ANT + 1) / 2;
  localparam int CH_W = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;
  localparam int CO_W = (NUM_CORR > 1) ? $clog2(NUM_CORR) : 1;
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int AW = BIN_W + CH_W + CO_W;
  localparam int DEPTH = 1 << AW;
  // Cell word: epoch, flag, weight sum, imaginary sum, real sum.
  localparam int EW = 8;
  localparam int CW = EW + 1 + 32 + 80;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_RD_I, S_RD_J, S_RD_J2, S_WR_I, S_RD_JA, S_WR_J, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] rdata_r;
  logic [NUM_BINS-1:0] seen_r;
  logic [EW-1:0] epoch_r;
  logic [AW-1:0] sweep_r;
  logic [AW-1:0] raddr, waddr;
  logic re, we;
  logic [CW-1:0] wdata;
  fwva_pkg::cmd_t cmd_r;
  logic acc_i_r, acc_j_r, zero_r;
  logic [39:0] pr_r, pi_r;
  logic [CW-1:0] cell_i_r;
  logic [39:0] sr, si;
  logic [31:0] ws;
  logic fl;
  logic div_go_r, div_re_done, div_im_done;
  logic [15:0] q_re, q_im;
  logic [71:0] out_data_r;
  logic out_user_r, out_valid_r;
  logic out_load;

  function automatic logic [AW-1:0] addr_of(logic [11:0] b, logic [11:0] c,
                                            logic [1:0] k);
    addr_of = {b[BIN_W-1:0], c[CH_W-1:0], k[CO_W-1:0]};
  endfunction

  // Cell as seen under the current epoch: stale entries read as reset.
  assign fl = (rdata_r[CW-1 -: EW] != epoch_r) ? 1'b1 : rdata_r[112];
  assign sr = (rdata_r[CW-1 -: EW] != epoch_r) ? 40'd0 : rdata_r[39:0];
  assign si = (rdata_r[CW-1 -: EW] != epoch_r) ? 40'd0 : rdata_r[79:40];
  assign ws = (rdata_r[CW-1 -: EW] != epoch_r) ? 32'd0 : rdata_r[111:80];

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  fwva_divider u_div_re (.clk, .rst_n, .start(div_go_r), .num(sr), .den(ws),
                         .done(div_re_done), .res(q_re));
  fwva_divider u_div_im (.clk, .rst_n, .start(div_go_r), .num(si), .den(ws),
                         .done(div_im_done), .res(q_im));

  // Memory port control.
  always_comb begin
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = '0;
    case (state_r)
      S_SWEEP: begin
        we = 1'b1;
        waddr = sweep_r;
        wdata = {epoch_r, 1'b1, 112'd0};
      end
      S_IDLE: begin
        re = 1'b1;
        raddr = addr_of(q_cmd.bin_i, q_cmd.chan, q_cmd.corr);
      end
      S_RD_I: begin
        re = 1'b1;
        raddr = addr_of(cmd_r.bin_j, cmd_r.chan, cmd_r.corr);
      end
      S_WR_I: begin
        we = acc_i_r || !cmd_r.flagged;
        waddr = addr_of(cmd_r.bin_i, cmd_r.chan, cmd_r.corr);
        wdata = {epoch_r, cell_i_r[112:0]};
      end
      S_RD_JA: begin
        re = 1'b1;
        raddr = addr_of(cmd_r.bin_j, cmd_r.chan, cmd_r.corr_j);
      end
      S_RD_J: begin
        we = !cmd_r.flagged;
        waddr = addr_of(cmd_r.bin_j, cmd_r.chan, cmd_r.corr);
        wdata = fl ? {epoch_r, 1'b0, 112'd0} : {epoch_r, rdata_r[112:0]};
      end
      S_WR_J: begin
        we = acc_j_r;
        waddr = addr_of(cmd_r.bin_j, cmd_r.chan, cmd_r.corr_j);
        wdata = {epoch_r, fl, ws + {16'd0, cmd_r.weight}, si - pi_r, sr + pr_r};
      end
      default: ;
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      sweep_r <= '0;
      seen_r <= '0;
      epoch_r <= '0;
      out_valid_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_SWEEP: begin
          sweep_r <= sweep_r + AW'(1);
          if (&sweep_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            pr_r <= 40'($signed(q_cmd.vr) * $signed({1'b0, q_cmd.weight}));
            pi_r <= 40'($signed(q_cmd.vi) * $signed({1'b0, q_cmd.weight}));
            case (q_cmd.kind)
              fwva_pkg::K_CLEAR: begin
                epoch_r <= epoch_r + EW'(1);
                seen_r <= '0;
                if (&epoch_r) state_r <= S_SWEEP;
              end
              fwva_pkg::K_ACC: begin
                seen_r[q_cmd.bin_i[BIN_W-1:0]] <= 1'b1;
                if (q_cmd.dual) seen_r[q_cmd.bin_j[BIN_W-1:0]] <= 1'b1;
                state_r <= S_RD_I;
              end
              fwva_pkg::K_READ: begin
                zero_r <= 1'b0;
                state_r <= S_DIV;
                div_go_r <= 1'b1;
              end
              default: begin
                zero_r <= 1'b1;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          // Data was loaded for the divider on entry; wait for it.
          if (div_re_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (zero_r) begin
              out_data_r <= '0;
              out_user_r <= 1'b0;
            end else begin
              out_data_r <= {7'd0, seen_r[cmd_r.bin_i[BIN_W-1:0]], ws,
                             (ws == 32'd0) ? 16'd0 : q_im,
                             (ws == 32'd0) ? 16'd0 : q_re};
              out_user_r <= fl;
            end
            state_r <= S_IDLE;
          end
        end
        S_RD_I: begin
          // Cell i in rdata: apply the flag rule.
          acc_i_r <= !cmd_r.flagged || fl;
          if (!cmd_r.flagged && fl)
            cell_i_r <= {epoch_r, 1'b0, 32'd0 + {16'd0, cmd_r.weight}, pi_r, pr_r};
          else
            cell_i_r <= {epoch_r, fl, ws + {16'd0, cmd_r.weight}, si + pi_r,
                         sr + pr_r};
          state_r <= cmd_r.dual ? S_RD_J : S_WR_I;
        end
        S_RD_J: begin
          // Cell j flag test and wipe on its unswapped correlation.
          acc_j_r <= !cmd_r.flagged || fl;
          state_r <= S_RD_J2;
        end
        S_RD_J2: state_r <= S_WR_I;
        S_WR_I: state_r <= cmd_r.dual ? S_RD_JA : S_IDLE;
        S_RD_JA: state_r <= S_WR_J;
        S_WR_J: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_re_done |-> div_im_done) else $error("dividers out of step");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r) else $error("result lost");
endmodule
`default_nettype wire

// ===== sv/flagged_weighted_visibility_averager_unit.sv =====
// Top level of the flagged weighted visibility averager.
// Depends on fwva_pkg, fwva_front, fwva_queue and fwva_back.
//
// A clear advances a store epoch; an accumulate updates one cell (two in
// per-antenna mode) in the cell store; a read waits on the bit-serial
// 40-by-32 divider, and longer while an earlier result is still held on
// the output. After reset, and after every 256th clear when the epoch
// wraps, the back part sweeps the whole cell store (65536 entries with the
// default sizes) to its reset value one entry a cycle; input words stall
// once the two-entry queue is full.
`default_nettype none
module flagged_weighted_visibility_averager_unit #(
  parameter int NUM_ANT  = fwva_pkg::NUM_ANT_DEF,
  parameter int NUM_CHAN = fwva_pkg::NUM_CHAN_DEF,
  parameter int NUM_CORR = fwva_pkg::NUM_CORR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op, antenna_one, antenna_two, channel, correlation, weight, vis_real,
  // vis_imag, read_bin (from bit 0 up), zero filled
  input  wire logic [79:0] in_tdata,
  // in_flagged
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // avg_real, avg_imag, avg_weight, bin_present (from bit 0 up), zero filled
  output logic [71:0]      out_tdata,
  // cell_flagged
  output logic             out_tuser
);
  logic [5:0] regs;
  logic cfg_we, q_push, q_full, q_valid, q_pop;
  fwva_pkg::cmd_t f_cmd, b_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      fwva_pkg::REG_MODE:   cfg_prdata = {30'd0, regs[1:0]};
      fwva_pkg::REG_SWAP_A: cfg_prdata = {30'd0, regs[3:2]};
      fwva_pkg::REG_SWAP_B: cfg_prdata = {30'd0, regs[5:4]};
      default: cfg_prdata = '0;
    endcase
  end

  fwva_front #(.NUM_ANT(NUM_ANT), .NUM_CHAN(NUM_CHAN), .NUM_CORR(NUM_CORR)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_paddr[3:2]), .cfg_val(cfg_pwdata[1:0]),
    .cfg_regs(regs), .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[1:0]), .ant1(in_tdata[5:2]), .ant2(in_tdata[9:6]),
    .chan(in_tdata[15:10]), .corr(in_tdata[17:16]), .flg(in_tuser),
    .wgt(in_tdata[33:18]), .vr(in_tdata[49:34]), .vi(in_tdata[65:50]),
    .rbin(in_tdata[73:66]), .q_push, .q_cmd(f_cmd), .q_full);

  fwva_queue u_queue (.clk, .rst_n, .push(q_push), .din(f_cmd), .full(q_full),
    .valid(q_valid), .dout(b_cmd), .pop(q_pop));

  fwva_back #(.NUM_ANT(NUM_ANT), .NUM_CHAN(NUM_CHAN), .NUM_CORR(NUM_CORR)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd(b_cmd), .q_pop, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser);
endmodule
`default_nettype wire
